### design/srrw_pkg.sv
// shared constants for the selective-repeat receive window
package srrw_pkg;

  // default sizing, handed to the top level parameters
  localparam int unsigned WINDOW_MAX_DEF = 32;
  localparam int unsigned TAG_BITS_DEF   = 16;

  // fixed field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned CFG_W  = 6;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd8;

  // packet types
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_END   = 2'd1;
  localparam logic [OP_W-1:0] OP_DATA  = 2'd2;

  // result kinds
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

endpackage

### design/selective_repeat_receive_window_unit.sv
// selective-repeat receive window: session control, reorder buffer and in-order release
//
// One packet header is taken per transfer on start/busy. Start packets, end packets,
// bad-checksum packets, packets outside the window and packets stored ahead of the
// expected number are finished at the transfer edge itself: busy stays low and any
// acknowledgement appears in the next cycle, so such headers can follow every cycle.
// A data packet at the expected number releases its own handle, then every buffered
// successor, then one acknowledgement with the received number; with k buffered
// successors busy stays high through the release and k + 2 results follow: the own handle
// in the cycle after the transfer, a gap while the first slot is read, then one result per
// cycle, the acknowledgement showing in the first cycle with busy low again. The release
// pace is set by the single read port of the tag memory, which gives one
// buffered handle per cycle. Results are shown for one cycle each under res_valid_o
// and cannot be held off, so a receiver must take every strobe. The window register
// is written on its own valid/ready channel, which is always ready; write it only
// while busy is low and no result is outstanding. No clearing pass is needed after
// reset: slot occupancy lives in flip-flops cleared at once, the tags in a memory.
module selective_repeat_receive_window_unit
  import srrw_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int unsigned TAG_BITS   = TAG_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // header transfer
  input  logic             start,
  output logic             busy,
  input  logic [OP_W-1:0]  opcode_i,
  input  logic [SEQ_W-1:0] seq_num_i,
  input  logic             checksum_ok_i,
  input  logic [TAG_W-1:0] payload_tag_i,
  // results
  output logic             res_valid_o,
  output logic             kind_o,
  output logic [SEQ_W-1:0] ack_seq_o,
  output logic [TAG_W-1:0] out_tag_o,
  output logic             last_o,
  // window size register
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned IW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned WB  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned EW  = (WB > CFG_W) ? WB : CFG_W;
  localparam logic [EW-1:0] WMAX_E = EW'(WINDOW_MAX);
  localparam logic [IW:0]   WMAX_I = (IW + 1)'(WINDOW_MAX);
  localparam logic [IW-1:0] TOP_IDX = IW'(WINDOW_MAX - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_ACK
  } state_e;

  state_e                state_q;
  logic [CFG_W-1:0]      window_q;
  logic                  active_q;
  logic [SEQ_W-1:0]      start_seq_q;
  logic [SEQ_W-1:0]      exp_q;
  logic [IW-1:0]         head_q;
  logic [WINDOW_MAX-1:0] valid_q;
  logic                  rd_pend_q;
  logic [SEQ_W-1:0]      ack_hold_q;
  logic                  res_valid_q;
  logic                  kind_q;
  logic [SEQ_W-1:0]      ack_seq_q;
  logic [TAG_W-1:0]      out_tag_q;
  logic                  last_q;

  // tag store, one entry per physical slot
  logic [TAG_BITS-1:0]   tag_mem [WINDOW_MAX];
  logic [TAG_BITS-1:0]   rdata_q;

  logic                  accept;
  logic [EW-1:0]         win_ext;
  logic [EW-1:0]         eff_win;
  logic [SEQ_W-1:0]      offset;
  logic                  in_win;
  logic [IW:0]           slot_sum;
  logic [IW-1:0]         wr_idx;
  logic [IW-1:0]         head_nxt;
  logic [TAG_BITS-1:0]   tag_in;
  logic                  is_start;
  logic                  end_match;
  logic                  mem_we;
  logic                  rd_en;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // clamp the window register to 1 .. WINDOW_MAX
  assign win_ext = EW'(window_q);
  always_comb begin
    if (win_ext == '0) begin
      eff_win = EW'(1);
    end else if (win_ext > WMAX_E) begin
      eff_win = WMAX_E;
    end else begin
      eff_win = win_ext;
    end
  end

  // distance ahead of the expected number, modulo 2^32
  assign offset = seq_num_i - exp_q;
  assign in_win = (offset != '0) && (offset < SEQ_W'(eff_win));

  // logical slot k sits at physical (head + k) mod WINDOW_MAX
  assign slot_sum = {1'b0, head_q} + {1'b0, offset[IW-1:0]};
  assign wr_idx   = (slot_sum >= WMAX_I) ? IW'(slot_sum - WMAX_I) : slot_sum[IW-1:0];
  assign head_nxt = (head_q == TOP_IDX) ? '0 : head_q + 1'b1;

  assign tag_in    = TAG_BITS'(payload_tag_i);
  assign is_start  = (opcode_i == OP_START);
  assign end_match = (opcode_i == OP_END) && (seq_num_i == start_seq_q);

  // buffer a good data packet ahead of the expected number
  assign mem_we = (state_q == ST_IDLE) && accept && active_q && !is_start && !end_match &&
                  checksum_ok_i && in_win;
  // release reads only happen while busy, so they never meet a write
  assign rd_en  = (state_q == ST_DRAIN) && valid_q[head_q];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[wr_idx] <= tag_in;
    end
    if (rd_en) begin
      rdata_q <= tag_mem[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= WINDOW_RESET;
      active_q    <= 1'b0;
      start_seq_q <= '0;
      exp_q       <= '0;
      head_q      <= '0;
      valid_q     <= '0;
      rd_pend_q   <= 1'b0;
      ack_hold_q  <= '0;
      res_valid_q <= 1'b0;
      kind_q      <= KIND_ACK;
      ack_seq_q   <= '0;
      out_tag_q   <= '0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        window_q <= cfg_wdata_i;
      end
      res_valid_q <= 1'b0;
      rd_pend_q   <= rd_en;

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (!active_q) begin
              // only a start opens a session, anything else is dropped
              if (is_start) begin
                active_q    <= 1'b1;
                start_seq_q <= seq_num_i;
                exp_q       <= '0;
                head_q      <= '0;
                valid_q     <= '0;
                res_valid_q <= 1'b1;
                kind_q      <= KIND_ACK;
                ack_seq_q   <= seq_num_i;
                out_tag_q   <= '0;
                last_q      <= 1'b1;
              end
            end else if (is_start) begin
              // repeated start, acknowledge the recorded number again
              res_valid_q <= 1'b1;
              kind_q      <= KIND_ACK;
              ack_seq_q   <= start_seq_q;
              out_tag_q   <= '0;
              last_q      <= 1'b1;
            end else if (end_match) begin
              // close the session and empty the window
              active_q    <= 1'b0;
              exp_q       <= '0;
              head_q      <= '0;
              valid_q     <= '0;
              res_valid_q <= 1'b1;
              kind_q      <= KIND_ACK;
              ack_seq_q   <= seq_num_i;
              out_tag_q   <= '0;
              last_q      <= 1'b1;
            end else if (checksum_ok_i) begin
              if (offset == '0) begin
                // in-order packet goes straight out, buffered successors follow
                res_valid_q <= 1'b1;
                kind_q      <= KIND_DATA;
                ack_seq_q   <= '0;
                out_tag_q   <= TAG_W'(tag_in);
                last_q      <= 1'b0;
                exp_q       <= exp_q + 1'b1;
                head_q      <= head_nxt;
                ack_hold_q  <= seq_num_i;
                state_q     <= ST_DRAIN;
              end else begin
                if (in_win) begin
                  valid_q[wr_idx] <= 1'b1;
                end
                res_valid_q <= 1'b1;
                kind_q      <= KIND_ACK;
                ack_seq_q   <= seq_num_i;
                out_tag_q   <= '0;
                last_q      <= 1'b1;
              end
            end
          end
        end

        ST_DRAIN: begin
          // handle read in the previous cycle is out of the memory now
          if (rd_pend_q) begin
            res_valid_q <= 1'b1;
            kind_q      <= KIND_DATA;
            ack_seq_q   <= '0;
            out_tag_q   <= TAG_W'(rdata_q);
            last_q      <= 1'b0;
          end
          if (valid_q[head_q]) begin
            valid_q[head_q] <= 1'b0;
            head_q          <= head_nxt;
            exp_q           <= exp_q + 1'b1;
          end else begin
            state_q <= ST_ACK;
          end
        end

        ST_ACK: begin
          res_valid_q <= 1'b1;
          kind_q      <= KIND_ACK;
          ack_seq_q   <= ack_hold_q;
          out_tag_q   <= '0;
          last_q      <= 1'b1;
          state_q     <= ST_IDLE;
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign kind_o      = kind_q;
  assign ack_seq_o   = ack_seq_q;
  assign out_tag_o   = out_tag_q;
  assign last_o      = last_q;

endmodule

### design/srrw_checker.sv
// port-level checks for the selective-repeat receive window, bound to the top level
module srrw_checker
  import srrw_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             res_valid_o,
  input logic             kind_o,
  input logic [SEQ_W-1:0] ack_seq_o,
  input logic [TAG_W-1:0] out_tag_o,
  input logic             last_o
);

  // a release burst only begins from an accepted header
  a_busy_from_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without a header transfer");

  // the end of a burst coincides with its closing acknowledgement
  a_burst_ends_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (res_valid_o && last_o && (kind_o == KIND_ACK)))
    else $error("burst ended without a final acknowledgement");

  // a result that is not the last of its header belongs to a running burst
  a_more_means_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |-> (busy && (kind_o == KIND_DATA)))
    else $error("non-final result outside a release burst");

  // unused field of each result kind reads zero
  a_unused_field_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ((kind_o == KIND_ACK) ? (out_tag_o == '0) : (ack_seq_o == '0)))
    else $error("unused result field not zero");

endmodule

bind selective_repeat_receive_window_unit srrw_checker u_srrw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .kind_o      (kind_o),
  .ack_seq_o   (ack_seq_o),
  .out_tag_o   (out_tag_o),
  .last_o      (last_o)
);

### dv/selective_repeat_receive_window_unit_tb.sv
// testbench for the selective-repeat receive window: directed sessions, window limits, random traffic
`timescale 1ns / 100ps

module selective_repeat_receive_window_unit_tb;
  import srrw_pkg::*;

  // opcode 3 has no name in the package; in a session it counts as data
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam int unsigned SLOTS         = WINDOW_MAX_DEF;
  localparam int unsigned SETTLE_CYCLES = 4;      // no-result headers finish at the transfer edge
  localparam int unsigned TAIL_CYCLES   = 40;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned PHASE_ITEMS   = 46;

  // one answer of the window: acknowledgement or in-order handle
  typedef struct packed {
    logic             kind;
    logic [SEQ_W-1:0] ack_seq;
    logic [TAG_W-1:0] out_tag;
    logic             last;
  } answer_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [OP_W-1:0]  opcode_i = '0;
  logic [SEQ_W-1:0] seq_num_i = '0;
  logic             checksum_ok_i = 1'b0;
  logic [TAG_W-1:0] payload_tag_i = '0;
  logic             res_valid_o;
  logic             kind_o;
  logic [SEQ_W-1:0] ack_seq_o;
  logic [TAG_W-1:0] out_tag_o;
  logic             last_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  selective_repeat_receive_window_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .seq_num_i     (seq_num_i),
    .checksum_ok_i (checksum_ok_i),
    .payload_tag_i (payload_tag_i),
    .res_valid_o   (res_valid_o),
    .kind_o        (kind_o),
    .ack_seq_o     (ack_seq_o),
    .out_tag_o     (out_tag_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // receiver mirror: session flag, numbers and the reorder slots
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] window_reg = WINDOW_RESET;
  logic             in_session = 1'b0;
  logic [SEQ_W-1:0] first_seq  = '0;    // number of the opening start packet
  logic [SEQ_W-1:0] next_seq   = '0;    // number expected next in order
  logic             held       [SLOTS];
  logic [TAG_W-1:0] held_tag   [SLOTS];

  answer_t answers_due[$];              // answers predicted but not yet seen

  int unsigned sender_idle_pct = 0;
  int unsigned cycle_count     = 0;
  int unsigned failures        = 0;
  int unsigned headers_sent    = 0;
  int unsigned answers_checked = 0;
  int unsigned window_writes   = 0;
  int unsigned longest_release = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      held[i]     = 1'b0;
      held_tag[i] = '0;
    end
  end

  // 0 behaves as 1, anything past the slot count as the slot count
  function automatic int unsigned usable_slots();
    if (window_reg == 0) return 1;
    if (window_reg > SLOTS) return SLOTS;
    return window_reg;
  endfunction

  // session close or open: empty every slot and restart numbering at zero
  task automatic empty_window();
    for (int i = 0; i < SLOTS; i++) begin
      held[i]     = 1'b0;
      held_tag[i] = '0;
    end
    next_seq = '0;
  endtask

  // work out the answers one accepted header causes and queue them in order
  task automatic predict_header(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
                                input logic ok, input logic [TAG_W-1:0] tag);
    answer_t          batch[$];
    logic [SEQ_W-1:0] offset;
    if (!in_session) begin
      // idle: only a start opens a session, everything else is dropped
      if (op != OP_START) return;
      in_session = 1'b1;
      first_seq  = seq;
      empty_window();
      batch.push_back('{KIND_ACK, seq, '0, 1'b0});
    end else if (op == OP_START) begin
      // repeated start: re-acknowledge with the recorded number
      batch.push_back('{KIND_ACK, first_seq, '0, 1'b0});
    end else if (op == OP_END && seq == first_seq) begin
      batch.push_back('{KIND_ACK, seq, '0, 1'b0});
      in_session = 1'b0;
      empty_window();
    end else begin
      // data, spare opcode, or an end with a foreign number
      if (!ok) return;
      offset = seq - next_seq;
      if (offset == 0) begin
        held[0]     = 1'b1;
        held_tag[0] = tag;
        // release the head and every buffered successor, one slot at a time
        while (held[0]) begin
          batch.push_back('{KIND_DATA, '0, held_tag[0], 1'b0});
          for (int i = 0; i < SLOTS - 1; i++) begin
            held[i]     = held[i + 1];
            held_tag[i] = held_tag[i + 1];
          end
          held[SLOTS-1]     = 1'b0;
          held_tag[SLOTS-1] = '0;
          next_seq++;
        end
      end else if (offset < usable_slots()) begin
        held[offset]     = 1'b1;
        held_tag[offset] = tag;
      end
      batch.push_back('{KIND_ACK, seq, '0, 1'b0});
    end
    batch[batch.size()-1].last = 1'b1;
    if (batch.size() > longest_release) longest_release = batch.size();
    foreach (batch[i]) answers_due.push_back(batch[i]);
  endtask

  // ---------------------------------------------------------------------------
  // driving: inputs move on the falling edge, handshakes are sampled on the rising
  // ---------------------------------------------------------------------------

  // one header transfer; start is left high so a following header can go back to back
  task automatic send_header(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
                             input logic ok, input logic [TAG_W-1:0] tag);
    @(negedge clk_i);
    // busy only moves on the rising edge, so its value here holds up to the next one
    while (busy || ($urandom_range(99) < sender_idle_pct)) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start         <= 1'b1;
    opcode_i      <= op;
    seq_num_i     <= seq;
    checksum_ok_i <= ok;
    payload_tag_i <= tag;
    @(posedge clk_i);
    headers_sent++;
    predict_header(op, seq, ok, tag);
  endtask

  // drop start and wait until every predicted answer has come back
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // window register write, only ever with the block quiet
  task automatic write_window(input logic [CFG_W-1:0] value);
    settle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    window_reg = value;
    window_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // checking: every strobe against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic note_failure(input string what, input answer_t want, input answer_t got);
    failures++;
    if (failures <= REPORT_LIMIT)
      $display("%0t %s: want kind %0d seq %h tag %h last %0d, got kind %0d seq %h tag %h last %0d",
               $realtime, what, want.kind, want.ack_seq, want.out_tag, want.last,
               got.kind, got.ack_seq, got.out_tag, got.last);
  endtask

  always @(posedge clk_i) begin : answer_check
    answer_t got;
    answer_t want;
    if (rst_ni && res_valid_o) begin
      got = '{kind_o, ack_seq_o, out_tag_o, last_o};
      answers_checked++;
      if (answers_due.size() == 0) begin
        note_failure("unexpected answer", '0, got);
      end else begin
        want = answers_due.pop_front();
        if (got !== want) note_failure("answer mismatch", want, got);
      end
    end
  end

  // hard stop for a hung handshake or a lost answer
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers still due", cycle_count, answers_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // idle drops, start/repeat/end rules, checksum, stale and out-of-window data
  task automatic test_session_rules();
    send_header(OP_DATA, 32'd0, 1'b1, 16'h1111);          // idle, dropped
    send_header(OP_END, 32'd0, 1'b1, 16'h2222);           // idle, dropped
    send_header(OP_SPARE, 32'd0, 1'b1, 16'h3333);         // idle, dropped
    send_header(OP_START, 32'hFFFF_FFFF, 1'b0, 16'h0000); // start ignores the checksum
    send_header(OP_START, 32'h0000_1234, 1'b1, 16'h0000); // repeat: acked with the first number
    send_header(OP_DATA, 32'd2, 1'b1, 16'hFFFF);          // ahead, buffered
    send_header(OP_DATA, 32'd3, 1'b0, 16'hDEAD);          // bad checksum, silent
    send_header(OP_DATA, 32'd7, 1'b1, 16'h0001);          // last slot of the window
    send_header(OP_DATA, 32'd8, 1'b1, 16'hBEEF);          // one past the window, ack only
    send_header(OP_DATA, 32'hFFFF_FFFF, 1'b1, 16'h0BAD);  // stale, wraps to a huge offset
    send_header(OP_END, 32'd1, 1'b1, 16'h0F0F);           // foreign end number, treated as data
    send_header(OP_END, 32'd9, 1'b0, 16'h0F0F);           // same, bad checksum
    send_header(OP_SPARE, 32'd0, 1'b1, 16'hA5A5);         // releases 0, 1 and 2
    send_header(OP_DATA, 32'd3, 1'b1, 16'h5A5A);          // releases 3 only
    send_header(OP_END, 32'hFFFF_FFFF, 1'b0, 16'h0000);   // closes despite the checksum
    send_header(OP_START, 32'd0, 1'b1, 16'h0000);
    send_header(OP_END, 32'd0, 1'b1, 16'h0000);
  endtask

  // register extremes: zero acts as one slot, 63 as the full slot count
  task automatic test_window_limits();
    write_window(6'd0);
    send_header(OP_START, 32'h8000_0000, 1'b1, 16'h0000);
    send_header(OP_DATA, 32'd1, 1'b1, 16'h1234);          // not stored with a single slot
    send_header(OP_DATA, 32'd0, 1'b1, 16'h4321);
    send_header(OP_DATA, 32'd1, 1'b1, 16'h5678);
    send_header(OP_END, 32'h8000_0000, 1'b1, 16'h0000);
    write_window(6'd63);
    send_header(OP_START, 32'h7FFF_FFFF, 1'b1, 16'h0000);
    send_header(OP_DATA, 32'd31, 1'b1, 16'hC0DE);         // top slot
    send_header(OP_DATA, 32'd32, 1'b1, 16'hC0DF);         // beyond every slot
    send_header(OP_END, 32'h7FFF_FFFF, 1'b1, 16'h0000);
  endtask

  // shrinking the window mid-session keeps what is already buffered
  task automatic test_window_resize_mid_session();
    write_window(6'd32);
    send_header(OP_START, 32'h0000_5A5A, 1'b1, 16'h0000);
    send_header(OP_DATA, 32'd5, 1'b1, 16'h0005);
    send_header(OP_DATA, 32'd20, 1'b1, 16'h0014);
    write_window(6'd2);
    send_header(OP_DATA, 32'd3, 1'b1, 16'h0003);          // now outside, ack only
    send_header(OP_DATA, 32'd1, 1'b1, 16'h0001);
    send_header(OP_DATA, 32'd0, 1'b1, 16'h0000);          // releases 0 and 1
    send_header(OP_DATA, 32'd2, 1'b1, 16'h0002);
    send_header(OP_DATA, 32'd3, 1'b1, 16'h0003);
    send_header(OP_DATA, 32'd4, 1'b1, 16'h0004);          // releases 4 and the old 5
    send_header(OP_END, 32'h0000_5A5A, 1'b1, 16'h0000);
  endtask

  // fill every usable slot in shuffled order, then send the head to drain them all
  task automatic fill_and_drain(ref int unsigned sent);
    int unsigned      order[$];
    int unsigned      pick;
    int unsigned      swap;
    logic [SEQ_W-1:0] base;
    base = next_seq;
    for (int unsigned k = 1; k < usable_slots(); k++) order.push_back(k);
    for (int i = order.size() - 1; i > 0; i--) begin
      pick        = $urandom_range(i);
      swap        = order[i];
      order[i]    = order[pick];
      order[pick] = swap;
    end
    foreach (order[i]) begin
      send_header(OP_DATA, base + order[i], 1'b1, TAG_W'($urandom));
      sent++;
    end
    send_header(OP_DATA, base, 1'b1, TAG_W'($urandom));
    sent++;
  endtask

  // mostly well-formed sessions with random content, some noise and broken traffic
  task automatic random_phase(input int unsigned n_items);
    int unsigned      sent;
    int unsigned      session_left;
    int unsigned      roll;
    logic [SEQ_W-1:0] near;
    sent         = 0;
    session_left = 0;
    while (sent < n_items) begin
      near = next_seq + $urandom_range(usable_slots() + 1);
      if (!in_session) begin
        if ($urandom_range(9) == 0) begin
          // idle noise, dropped by the block and not counted
          roll = $urandom_range(2);
          send_header(roll == 0 ? OP_END : (roll == 1 ? OP_DATA : OP_SPARE),
                      $urandom, 1'($urandom_range(1)), TAG_W'($urandom));
        end else begin
          send_header(OP_START, $urandom, 1'($urandom_range(1)), TAG_W'($urandom));
          session_left = $urandom_range(30, 6);
          sent++;
        end
      end else if (session_left == 0) begin
        send_header(OP_END, first_seq, 1'($urandom_range(1)), TAG_W'($urandom));
        sent++;
      end else begin
        roll = $urandom_range(99);
        session_left--;
        if (roll < 8) begin
          fill_and_drain(sent);
        end else begin
          if (roll < 50)
            send_header(OP_DATA, $urandom_range(3) == 0 ? next_seq : near, 1'b1,
                        TAG_W'($urandom));
          else if (roll < 58)
            send_header($urandom_range(1) ? OP_DATA : OP_SPARE, near, 1'b0, TAG_W'($urandom));
          else if (roll < 66)
            send_header(OP_DATA, next_seq - $urandom_range(40, 1), 1'b1, TAG_W'($urandom));
          else if (roll < 72)
            send_header(OP_DATA, $urandom, 1'b1, TAG_W'($urandom));
          else if (roll < 78)
            send_header(OP_START, $urandom, 1'($urandom_range(1)), TAG_W'($urandom));
          else if (roll < 84)
            send_header(OP_END, near, 1'($urandom_range(1)), TAG_W'($urandom));
          else if (roll < 90)
            send_header(OP_SPARE, near, 1'b1, TAG_W'($urandom));
          else
            send_header(OP_DATA, next_seq, 1'b1, TAG_W'($urandom));
          sent++;
        end
      end
    end
  endtask

  // random traffic under several window settings and sender gap rates
  task automatic test_random_traffic();
    sender_idle_pct = 0;
    write_window(6'd8);
    random_phase(PHASE_ITEMS);
    sender_idle_pct = 87;
    write_window(6'd1);
    random_phase(PHASE_ITEMS);
    sender_idle_pct = 12;
    write_window(6'd63);
    random_phase(PHASE_ITEMS);
    sender_idle_pct = 0;
    write_window(6'd32);
    random_phase(PHASE_ITEMS);
    sender_idle_pct = 87;
    write_window(6'd2);
    random_phase(PHASE_ITEMS);
    sender_idle_pct = 12;
    write_window(CFG_W'($urandom_range(32, 1)));
    random_phase(PHASE_ITEMS);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_session_rules();
    test_window_limits();
    test_window_resize_mid_session();
    test_random_traffic();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    failures += answers_due.size();

    $display("run covered %0d header transfers and %0d checked answers over %0d window writes",
             headers_sent, answers_checked, window_writes);
    $display("longest in-order release was %0d answers, %0d failures", longest_release, failures);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
design/srrw_pkg.sv
design/selective_repeat_receive_window_unit.sv
design/srrw_checker.sv
dv/selective_repeat_receive_window_unit_tb.sv
